// ===== rtl/core/cps_pkg.sv =====
// Shared types and constants for the closest-point-on-segment block.
`timescale 1ns / 1ps
`default_nettype none
package cps_pkg;

   // Which branch produced the result
   typedef enum logic [1:0] {
      CASE_ZERO     = 2'd0,
      CASE_CLAMP_A  = 2'd1,
      CASE_CLAMP_B  = 2'd2,
      CASE_INTERIOR = 2'd3
   } case_type;

endpackage
`default_nettype wire

// ===== rtl/core/cps_fifo.sv =====
// Short decoupling queue between the classify front and the divide back end.
`timescale 1ns / 1ps
`default_nettype none
module cps_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_valid,
   output logic                  wr_stall,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  rd_valid,
   input  wire logic             rd_stall,
   output logic [WIDTH-1:0]      rd_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             push, pop;

   assign wr_stall = (cnt_ff == (AW+1)'(DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rptr_ff];
   assign push     = wr_valid && !wr_stall;
   assign pop      = rd_valid && !rd_stall;

   // pointer and count update
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (push) wptr_in = (wptr_ff == AW'(DEPTH-1)) ? '0 : wptr_ff + 1'b1;
      if (pop)  rptr_in = (rptr_ff == AW'(DEPTH-1)) ? '0 : rptr_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) mem_ff[wptr_ff] <= wr_data;
   end
endmodule
`default_nettype wire

// ===== rtl/core/cps_front.sv =====
// Front end: differences, squared length, dot product and branch classification.
`timescale 1ns / 1ps
`default_nettype none
module cps_front #(
   parameter int CB = 16,
   parameter int QW = 4 * CB + 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_stall,
   input  wire logic signed [CB-1:0] a_x, a_y, b_x, b_y, p_x, p_y,
   output logic                      q_valid,
   input  wire logic                 q_stall,
   output logic [QW-1:0]             q_data
);
   import cps_pkg::*;

   localparam int DW = CB + 1;       // difference width
   localparam int PW = 2 * DW + 1;   // sum of two products

   // stage 1: differences
   logic                 s1_v_ff;
   logic signed [CB-1:0] s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff;
   logic signed [DW-1:0] s1_ux_ff, s1_uy_ff, s1_vx_ff, s1_vy_ff;
   // stage 2: products
   logic                 s2_v_ff;
   logic signed [CB-1:0] s2_ax_ff, s2_ay_ff, s2_bx_ff, s2_by_ff;
   logic signed [DW-1:0] s2_ux_ff, s2_uy_ff;
   logic signed [PW-1:0] s2_len_ff, s2_dot_ff;
   logic                 s2_zero_ff;
   logic                 adv;
   case_type             cls;

   assign adv      = !(s2_v_ff && q_stall);
   assign in_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
      end
      if (adv) begin
         s1_ax_ff <= a_x; s1_ay_ff <= a_y; s1_bx_ff <= b_x; s1_by_ff <= b_y;
         s1_ux_ff <= DW'(a_x) - DW'(b_x);
         s1_uy_ff <= DW'(a_y) - DW'(b_y);
         s1_vx_ff <= DW'(a_x) - DW'(p_x);
         s1_vy_ff <= DW'(a_y) - DW'(p_y);
         s2_ax_ff <= s1_ax_ff; s2_ay_ff <= s1_ay_ff;
         s2_bx_ff <= s1_bx_ff; s2_by_ff <= s1_by_ff;
         s2_ux_ff <= s1_ux_ff; s2_uy_ff <= s1_uy_ff;
         s2_zero_ff <= (s1_ux_ff == '0) && (s1_uy_ff == '0);
         s2_len_ff <= PW'(s1_ux_ff * s1_ux_ff) + PW'(s1_uy_ff * s1_uy_ff);
         s2_dot_ff <= PW'(s1_ux_ff * s1_vx_ff) + PW'(s1_uy_ff * s1_vy_ff);
      end
   end

   // classify on exact dot product and length
   always_comb begin
      if (s2_zero_ff)                cls = CASE_ZERO;
      else if (s2_dot_ff <= 0)       cls = CASE_CLAMP_A;
      else if (s2_dot_ff >= s2_len_ff) cls = CASE_CLAMP_B;
      else                           cls = CASE_INTERIOR;
   end

   assign q_valid = s2_v_ff;
   assign q_data  = QW'({cls, s2_ax_ff, s2_ay_ff, s2_bx_ff, s2_by_ff, s2_ux_ff, s2_uy_ff,
                        s2_len_ff[PW-2:0], s2_dot_ff[PW-2:0]});
endmodule
`default_nettype wire

// ===== rtl/core/cps_back.sv =====
// Back end: pipelined restoring divide for t, interpolation and rounding.
`timescale 1ns / 1ps
`default_nettype none
module cps_back #(
   parameter int CB = 16,
   parameter int FB = 16,
   parameter int QW = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   output logic                  q_stall,
   input  wire logic [QW-1:0]    q_data,
   output logic                  out_valid,
   input  wire logic             out_stall,
   output logic signed [CB-1:0]  near_x,
   output logic signed [CB-1:0]  near_y,
   output logic [1:0]            case_code
);
   import cps_pkg::*;

   localparam int DW = CB + 1;
   localparam int LW = 2 * DW;         // unsigned length / dot magnitude
   localparam int NS = FB + 3;         // input + divide stages + multiply + round and select out
   localparam int MW = DW + FB + 2;

   typedef struct packed {
      logic [1:0]           cls;
      logic signed [CB-1:0] ax, ay, bx, by;
      logic signed [DW-1:0] ux, uy;
      logic [LW-1:0]        len;
      logic [LW-1:0]        rem;
      logic [FB-1:0]        t;
   } item_type;

   item_type  st_ff [FB+1];
   item_type  st_in [FB];
   logic      v_ff [NS];
   logic      adv;
   item_type  head;
   logic [LW:0] sh [FB];

   logic signed [MW-1:0] px_ff, py_ff;
   logic signed [CB-1:0] mx_ax_ff, mx_ay_ff, mx_bx_ff, mx_by_ff;
   logic [1:0]           mx_cls_ff;
   logic signed [MW-1:0] rx, ry;
   logic signed [CB-1:0] o_x_ff, o_y_ff;
   logic [1:0]           o_cls_ff;

   assign adv     = !(v_ff[NS-1] && out_stall);
   assign q_stall = !adv;

   always_comb begin
      {head.cls, head.ax, head.ay, head.bx, head.by, head.ux, head.uy,
       head.len, head.rem} = q_data[QW-1:0];
      head.t = '0;
   end

   // one quotient bit per stage
   for (genvar i = 0; i < FB; i++) begin : g_div
      assign sh[i] = {st_ff[i].rem, 1'b0};
      always_comb begin
         st_in[i] = st_ff[i];
         if (sh[i] >= {1'b0, st_ff[i].len}) begin
            st_in[i].rem = LW'(sh[i] - {1'b0, st_ff[i].len});
            st_in[i].t   = {st_ff[i].t[FB-2:0], 1'b1};
         end else begin
            st_in[i].rem = LW'(sh[i]);
            st_in[i].t   = {st_ff[i].t[FB-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (adv) st_ff[i+1] <= st_in[i];
      end
   end

   // rounding of A*2^F - t*U
   assign rx = px_ff + (MW'(1) <<< (FB-1));
   assign ry = py_ff + (MW'(1) <<< (FB-1));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) v_ff[k] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= q_valid;
         for (int k = 1; k < NS; k++) v_ff[k] <= v_ff[k-1];
      end
      if (adv) begin
         st_ff[0] <= head;
         // interpolation multiply
         px_ff <= (MW'(st_ff[FB].ax) <<< FB)
                  - MW'($signed({1'b0, st_ff[FB].t}) * st_ff[FB].ux);
         py_ff <= (MW'(st_ff[FB].ay) <<< FB)
                  - MW'($signed({1'b0, st_ff[FB].t}) * st_ff[FB].uy);
         mx_ax_ff <= st_ff[FB].ax; mx_ay_ff <= st_ff[FB].ay;
         mx_bx_ff <= st_ff[FB].bx; mx_by_ff <= st_ff[FB].by;
         mx_cls_ff <= st_ff[FB].cls;
         // result select
         o_cls_ff <= mx_cls_ff;
         case (case_type'(mx_cls_ff))
            CASE_CLAMP_B: begin
               o_x_ff <= mx_bx_ff; o_y_ff <= mx_by_ff;
            end
            CASE_INTERIOR: begin
               o_x_ff <= CB'(rx >>> FB); o_y_ff <= CB'(ry >>> FB);
            end
            default: begin
               o_x_ff <= mx_ax_ff; o_y_ff <= mx_ay_ff;
            end
         endcase
      end
   end

   assign out_valid = v_ff[NS-1];
   assign near_x    = o_x_ff;
   assign near_y    = o_y_ff;
   assign case_code = o_cls_ff;
endmodule
`default_nettype wire

// ===== rtl/core/closest_point_on_segment.sv =====
// Top level: closest point on a 2-D segment, front classify + queue + divide back end.
// Pipeline: 2 front stages, 1 queue write, PARAM_FRAC_BITS+3 back stages.
// Throughput: one beat per cycle while no stall holds the pipes; the divide is one
// quotient bit per pipeline stage.
// Each side stalls on its own; the 4-entry queue absorbs the front pipe on a stall.
// Reset (synchronous, active high) empties all pipes and the queue; no other state.
`timescale 1ns / 1ps
`default_nettype none
module closest_point_on_segment #(
   parameter int COORD_BITS      = 16,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_a_x, req_a_y, req_b_x,
   input  wire logic signed [COORD_BITS-1:0] req_b_y, req_p_x, req_p_y,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0]      rsp_near_x,
   output logic signed [COORD_BITS-1:0]      rsp_near_y,
   output logic [1:0]                        rsp_case_code
);
   import cps_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int QW = 2 + 4 * COORD_BITS + 2 * DW + 4 * DW;

   logic          f_valid, f_stall, b_valid, b_stall;
   logic [QW-1:0] f_data, b_data;

   cps_front #(.CB(COORD_BITS), .QW(QW)) u_front (
      .clock, .reset, .in_valid(req_valid), .in_stall(req_stall),
      .a_x(req_a_x), .a_y(req_a_y), .b_x(req_b_x), .b_y(req_b_y),
      .p_x(req_p_x), .p_y(req_p_y),
      .q_valid(f_valid), .q_stall(f_stall), .q_data(f_data));

   cps_fifo #(.WIDTH(QW), .DEPTH(4)) u_fifo (
      .clock, .reset, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_data),
      .rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_data));

   cps_back #(.CB(COORD_BITS), .FB(PARAM_FRAC_BITS), .QW(QW)) u_back (
      .clock, .reset, .q_valid(b_valid), .q_stall(b_stall), .q_data(b_data),
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .near_x(rsp_near_x), .near_y(rsp_near_y), .case_code(rsp_case_code));

   // stalled beats stay put at the queue input and at the result output; no result is valid right after reset
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped under stall");
   a_fifo_flow: assert property (@(posedge clock) disable iff (reset)
      f_valid && f_stall |=> f_valid)
      else $error("front beat lost while queue full");
   a_req_rst: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
endmodule
`default_nettype wire
